>>> design/tsbe_pkg.sv
`default_nettype none

package tsbe_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned SeqW      = 32;
    localparam int unsigned CountW    = 3;
    localparam int unsigned NumBlocks = 4;
    localparam int unsigned IdxW      = 2;
    localparam int unsigned SkipW     = 4;
    localparam int unsigned PayloadW  = 6;
    localparam int unsigned InDataW   = 40;
    localparam int unsigned OutDataW  = 264;

    localparam logic [ByteW-1:0] KindEnd      = 8'd0;
    localparam logic [ByteW-1:0] KindNop      = 8'd1;
    localparam logic [ByteW-1:0] KindMss      = 8'd2;
    localparam logic [ByteW-1:0] KindWscale   = 8'd3;
    localparam logic [ByteW-1:0] KindSackPerm = 8'd4;
    localparam logic [ByteW-1:0] KindSack     = 8'd5;
    localparam logic [ByteW-1:0] KindTstamp   = 8'd8;

    localparam logic [ByteW-1:0] SackPayloadMax = 8'd32;

    // option parser phase
    typedef enum logic [2:0] {
        PH_KIND,
        PH_SKIP,
        PH_SACK_LEN,
        PH_SACK_DATA,
        PH_HOLD,
        PH_ZERO
    } t_phase;

    // end-of-area sequencer around the shared comparator
    typedef enum logic [3:0] {
        S_IN,
        S_DS0,
        S_DS1,
        S_DS2,
        S_P01,
        S_P23,
        S_P02,
        S_P13,
        S_P12,
        S_FIN
    } t_seq;

endpackage

`default_nettype wire

>>> design/tcp_sack_block_extractor.sv
`default_nettype none

// TCP SACK block extractor.
// The slave channel carries the option area of one segment, one byte per item;
// tlast marks the area's last byte, and local_sequence is taken from that byte.
// The master channel gives one result item per area: block_count and four
// sorted (left, right) edge pairs, zero beyond block_count.
// Ordinary option bytes are taken one per cycle. On the last byte the block
// drops tready and runs a short sequencer over one 32-bit serial-number
// comparator: three compares for the D-SACK test (only with two or more
// blocks) and up to five compare-and-swap steps, then a step to load the
// output register. The cost of an area's last byte is set by that sequencer:
// least with fewer than two blocks, most with four.
// The output register parts the two sides: a new area is parsed while a
// result waits, and the block only holds in its final load step while the
// receiver keeps tready low.
// Reset (synchronous, active low) returns the parser to expecting an option
// kind and empties the output register.
module tcp_sack_block_extractor
    import tsbe_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // [7:0] option_byte, [39:8] local_sequence
    input  wire logic [InDataW-1:0]  i_s_axis_tdata,
    // area_end
    input  wire logic                i_s_axis_tlast,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // [2:0] block_count, [34:3] left_edge_0, [66:35] right_edge_0,
    // [98:67] left_edge_1, [130:99] right_edge_1, [162:131] left_edge_2,
    // [194:163] right_edge_2, [226:195] left_edge_3, [258:227] right_edge_3,
    // [263:259] zero
    output logic [OutDataW-1:0]      o_m_axis_tdata
);

    t_phase                r_phase, n_phase;
    t_seq                  r_seq, n_seq;
    logic [SkipW-1:0]      r_skip, n_skip;
    logic [PayloadW-1:0]   r_pbl, n_pbl;
    logic [SeqW-1:0]       r_shift, n_shift;
    logic [CountW-1:0]     r_br, n_br;
    logic [CountW-1:0]     r_count, n_count;
    logic [SeqW-1:0]       r_seqnum;
    logic                  r_flag, r_c1;
    logic                  r_ovalid;

    logic [SeqW-1:0]       r_lf [NumBlocks];
    logic [SeqW-1:0]       r_rt [NumBlocks];
    logic [CountW-1:0]     r_o_count;
    logic [SeqW-1:0]       r_o_lf [NumBlocks];
    logic [SeqW-1:0]       r_o_rt [NumBlocks];

    logic [ByteW-1:0]      w_byte;
    logic                  w_accept;
    logic [SeqW-1:0]       w_edge;
    logic [ByteW-1:0]      w_plen;
    logic                  w_wr_lf, w_wr_rt;
    logic                  w_dsack;
    logic                  w_load;
    logic [SeqW-1:0]       w_cmp_a, w_cmp_b, w_diff;
    logic                  w_before;
    logic                  w_pair;
    logic [IdxW-1:0]       w_pi, w_pj;

    assign w_byte   = i_s_axis_tdata[ByteW-1:0];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_edge   = {r_shift[SeqW-ByteW-1:0], w_byte};
    assign w_plen   = w_byte - 8'd2;
    assign w_load   = (r_seq == S_FIN) && (!r_ovalid || i_m_axis_tready);

    // shared serial-number comparator: a is before b
    assign w_diff   = w_cmp_a - w_cmp_b;
    assign w_before = w_diff[SeqW-1];
    assign w_dsack  = r_flag || (!r_c1 && !w_before);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_seq   = r_seq;
        n_skip  = r_skip;
        n_pbl   = r_pbl;
        n_shift = r_shift;
        n_br    = r_br;
        n_count = r_count;
        w_wr_lf = 1'b0;
        w_wr_rt = 1'b0;
        unique case (r_seq)
            S_IN: begin
                if (w_accept) begin
                    unique case (r_phase)
                        PH_KIND: begin
                            if (w_byte == KindEnd || w_byte == KindNop) begin
                                n_phase = PH_KIND;
                            end else if (w_byte == KindSack) begin
                                n_phase = PH_SACK_LEN;
                            end else if (w_byte == KindMss) begin
                                n_skip  = 4'd3;
                                n_phase = PH_SKIP;
                            end else if (w_byte == KindWscale) begin
                                n_skip  = 4'd2;
                                n_phase = PH_SKIP;
                            end else if (w_byte == KindSackPerm) begin
                                n_skip  = 4'd1;
                                n_phase = PH_SKIP;
                            end else if (w_byte == KindTstamp) begin
                                n_skip  = 4'd9;
                                n_phase = PH_SKIP;
                            end else begin
                                n_phase = PH_ZERO;
                            end
                        end
                        PH_SKIP: begin
                            n_skip = r_skip - 4'd1;
                            if (n_skip == '0) begin
                                n_phase = PH_KIND;
                            end
                        end
                        PH_SACK_LEN: begin
                            n_br = '0;
                            if (w_byte <= 8'd2) begin
                                n_phase = PH_HOLD;
                            end else if (w_plen > SackPayloadMax || w_plen[2:0] != 3'd0) begin
                                n_phase = PH_ZERO;
                            end else begin
                                n_pbl   = w_plen[PayloadW-1:0];
                                n_shift = '0;
                                n_phase = PH_SACK_DATA;
                            end
                        end
                        PH_SACK_DATA: begin
                            n_shift = w_edge;
                            n_pbl   = r_pbl - 6'd1;
                            if (n_pbl[2:0] == 3'd4) begin
                                w_wr_lf = 1'b1;
                            end else if (n_pbl[2:0] == 3'd0) begin
                                w_wr_rt = 1'b1;
                                n_br    = r_br + 3'd1;
                            end
                            if (n_pbl == '0) begin
                                n_phase = PH_HOLD;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                    if (i_s_axis_tlast) begin
                        n_count = (n_phase == PH_HOLD) ? n_br : '0;
                        n_seq   = (n_count > 3'd1) ? S_DS0 : S_FIN;
                        n_phase = PH_KIND;
                        n_skip  = '0;
                        n_pbl   = '0;
                        n_shift = '0;
                        n_br    = '0;
                    end
                end
            end
            S_DS0: n_seq = S_DS1;
            S_DS1: n_seq = S_DS2;
            S_DS2: begin
                n_count = r_count - {2'b00, w_dsack};
                n_seq   = (n_count > 3'd1) ? S_P01 : S_FIN;
            end
            S_P01: begin
                if (r_count == 3'd4) begin
                    n_seq = S_P23;
                end else if (r_count == 3'd3) begin
                    n_seq = S_P02;
                end else begin
                    n_seq = S_FIN;
                end
            end
            S_P23: n_seq = S_P02;
            S_P02: n_seq = (r_count == 3'd4) ? S_P13 : S_P12;
            S_P13: n_seq = S_P12;
            S_P12: n_seq = S_FIN;
            S_FIN: begin
                if (w_load) begin
                    n_seq = S_IN;
                end
            end
            default: n_seq = S_IN;
        endcase
    end

    // outputs of the sequencer: handshake and comparator operands
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_pair  = 1'b0;
        w_pi    = 2'd0;
        w_pj    = 2'd1;
        w_cmp_a = r_lf[1];
        w_cmp_b = r_lf[0];
        unique case (r_seq)
            S_IN:  o_s_axis_tready = 1'b1;
            S_DS0: begin
                w_cmp_a = r_lf[0];
                w_cmp_b = r_seqnum;
            end
            S_DS1: begin
                w_cmp_a = r_rt[1];
                w_cmp_b = r_rt[0];
            end
            S_DS2: begin
                w_cmp_a = r_lf[0];
                w_cmp_b = r_lf[1];
            end
            S_P01: begin
                w_pair = 1'b1;
                w_pi   = 2'd0;
                w_pj   = 2'd1;
            end
            S_P23: begin
                w_pair = 1'b1;
                w_pi   = 2'd2;
                w_pj   = 2'd3;
            end
            S_P02: begin
                w_pair = 1'b1;
                w_pi   = 2'd0;
                w_pj   = 2'd2;
            end
            S_P13: begin
                w_pair = 1'b1;
                w_pi   = 2'd1;
                w_pj   = 2'd3;
            end
            S_P12: begin
                w_pair = 1'b1;
                w_pi   = 2'd1;
                w_pj   = 2'd2;
            end
            S_FIN: o_s_axis_tready = 1'b0;
            default: o_s_axis_tready = 1'b0;
        endcase
        if (w_pair) begin
            w_cmp_a = r_lf[w_pj];
            w_cmp_b = r_lf[w_pi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_KIND;
            r_seq    <= S_IN;
            r_skip   <= '0;
            r_pbl    <= '0;
            r_shift  <= '0;
            r_br     <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_seq   <= n_seq;
            r_skip  <= n_skip;
            r_pbl   <= n_pbl;
            r_shift <= n_shift;
            r_br    <= n_br;
            r_count <= n_count;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // edge store, D-SACK removal and in-place sort
    always_ff @(posedge i_clk) begin
        if (w_accept && i_s_axis_tlast) begin
            r_seqnum <= i_s_axis_tdata[InDataW-1:ByteW];
        end
        if (r_seq == S_DS0) begin
            r_flag <= w_before;
        end
        if (r_seq == S_DS1) begin
            r_c1 <= w_before;
        end
        if (w_wr_lf) begin
            r_lf[r_br[IdxW-1:0]] <= w_edge;
        end
        if (w_wr_rt) begin
            r_rt[r_br[IdxW-1:0]] <= w_edge;
        end
        if (r_seq == S_DS2 && w_dsack) begin
            // drop the first block, shift the rest down
            for (int k = 0; k < NumBlocks - 1; k++) begin
                r_lf[k] <= r_lf[k+1];
                r_rt[k] <= r_rt[k+1];
            end
            r_lf[NumBlocks-1] <= '0;
            r_rt[NumBlocks-1] <= '0;
        end
        if (w_pair && w_before) begin
            r_lf[w_pi] <= r_lf[w_pj];
            r_lf[w_pj] <= r_lf[w_pi];
            r_rt[w_pi] <= r_rt[w_pj];
            r_rt[w_pj] <= r_rt[w_pi];
        end
    end

    // output register, zero beyond the block count
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_count <= r_count;
            for (int k = 0; k < NumBlocks; k++) begin
                if (CountW'(k) < r_count) begin
                    r_o_lf[k] <= r_lf[k];
                    r_o_rt[k] <= r_rt[k];
                end else begin
                    r_o_lf[k] <= '0;
                    r_o_rt[k] <= '0;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'b00000,
                              r_o_rt[3], r_o_lf[3], r_o_rt[2], r_o_lf[2],
                              r_o_rt[1], r_o_lf[1], r_o_rt[0], r_o_lf[0],
                              r_o_count};

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tsbe_pkg::*;

    localparam int StallLimit    = 2000;
    localparam int HoldOffCycles = 300;
    localparam int DrainCycles   = 20;
    localparam int ItemsPerPhase = 170;

    typedef struct {
        logic [ByteW-1:0] opt;
        logic             last;
        logic [SeqW-1:0]  seq;
    } t_option_item;

    typedef struct {
        logic [CountW-1:0] count;
        logic [SeqW-1:0]   lft [NumBlocks];
        logic [SeqW-1:0]   rgt [NumBlocks];
    } t_sack_list;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [InDataW-1:0]  s_data  = '0;
    logic                s_last  = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [OutDataW-1:0] m_data;

    t_option_item     option_byte_q[$];
    t_sack_list       expected_sack_q[$];
    logic [ByteW-1:0] area_buf[$];

    int   tx_idle_pct  = 32;
    int   rx_idle_pct  = 72;
    int   hold_left    = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    int   err_count    = 0;
    int   stall_cycles = 0;
    logic in_took      = 1'b0;

    // option parser mirror
    t_phase      ph           = PH_KIND;
    logic [3:0]  skip_left    = '0;
    logic [7:0]  payload_left = '0;
    logic [31:0] edge_mem [8] = '{default: '0};
    logic [31:0] edge_shift   = '0;
    logic [2:0]  blocks_seen  = '0;

    tcp_sack_block_extractor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic serial_before(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic void advance_option_parser(logic [7:0] b, logic last,
                                                  logic [31:0] seq);
        t_sack_list  r;
        int          n;
        logic        dsack;
        logic        on;
        logic [31:0] t;
        logic [7:0]  plen;
        int          pi [5] = '{0, 2, 0, 1, 1};
        int          pj [5] = '{1, 3, 2, 3, 2};

        case (ph)
            PH_KIND: begin
                if (b == KindEnd || b == KindNop) begin
                    ph = PH_KIND;
                end else if (b == KindSack) begin
                    ph = PH_SACK_LEN;
                end else if (b == KindMss) begin
                    skip_left = 4'd3;
                    ph = PH_SKIP;
                end else if (b == KindWscale) begin
                    skip_left = 4'd2;
                    ph = PH_SKIP;
                end else if (b == KindSackPerm) begin
                    skip_left = 4'd1;
                    ph = PH_SKIP;
                end else if (b == KindTstamp) begin
                    skip_left = 4'd9;
                    ph = PH_SKIP;
                end else begin
                    ph = PH_ZERO;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 4'd1;
                if (skip_left == 4'd0)
                    ph = PH_KIND;
            end
            PH_SACK_LEN: begin
                blocks_seen = '0;
                plen = b - 8'd2;
                if (b <= 8'd2) begin
                    ph = PH_HOLD;
                end else if (plen > SackPayloadMax || plen[2:0] != 3'd0) begin
                    ph = PH_ZERO;
                end else begin
                    payload_left = plen;
                    edge_shift = '0;
                    ph = PH_SACK_DATA;
                end
            end
            PH_SACK_DATA: begin
                edge_shift = {edge_shift[23:0], b};
                payload_left = payload_left - 8'd1;
                if (payload_left[2:0] == 3'd4) begin
                    edge_mem[{blocks_seen[1:0], 1'b0}] = edge_shift;
                end else if (payload_left[2:0] == 3'd0) begin
                    edge_mem[{blocks_seen[1:0], 1'b1}] = edge_shift;
                    blocks_seen = blocks_seen + 3'd1;
                end
                if (payload_left == 8'd0)
                    ph = PH_HOLD;
            end
            default: ;
        endcase

        if (!last)
            return;

        for (int k = 0; k < NumBlocks; k++) begin
            r.lft[k] = '0;
            r.rgt[k] = '0;
        end
        n = 0;
        if (ph == PH_HOLD) begin
            n = (blocks_seen > 3'd4) ? 4 : int'(blocks_seen);
            for (int k = 0; k < n; k++) begin
                r.lft[k] = edge_mem[2*k];
                r.rgt[k] = edge_mem[2*k+1];
            end
            if (n > 1) begin
                // drop a leading duplicate report
                dsack = serial_before(r.lft[0], seq) ||
                        (!serial_before(r.rgt[1], r.rgt[0]) &&
                         !serial_before(r.lft[0], r.lft[1]));
                if (dsack) begin
                    for (int k = 0; k + 1 < n; k++) begin
                        r.lft[k] = r.lft[k+1];
                        r.rgt[k] = r.rgt[k+1];
                    end
                    n--;
                    r.lft[n] = '0;
                    r.rgt[n] = '0;
                end
                // fixed sorting network on left edges
                for (int s = 0; s < 5; s++) begin
                    on = (s == 0) ? (n > 1) : (s == 1 || s == 3) ? (n == 4) : (n > 2);
                    if (on && serial_before(r.lft[pj[s]], r.lft[pi[s]])) begin
                        t = r.lft[pi[s]];
                        r.lft[pi[s]] = r.lft[pj[s]];
                        r.lft[pj[s]] = t;
                        t = r.rgt[pi[s]];
                        r.rgt[pi[s]] = r.rgt[pj[s]];
                        r.rgt[pj[s]] = t;
                    end
                end
            end
        end
        r.count = CountW'(n);
        expected_sack_q.push_back(r);

        ph = PH_KIND;
        skip_left = '0;
        payload_left = '0;
        edge_shift = '0;
        blocks_seen = '0;
    endfunction

    function automatic void push_word(logic [31:0] w);
        area_buf.push_back(w[31:24]);
        area_buf.push_back(w[23:16]);
        area_buf.push_back(w[15:8]);
        area_buf.push_back(w[7:0]);
    endfunction

    // move the assembled area into the send queue, tlast on its final byte
    function automatic void queue_area(logic [31:0] seq_end);
        t_option_item it;
        foreach (area_buf[i]) begin
            it.opt  = area_buf[i];
            it.last = (i == area_buf.size() - 1);
            it.seq  = it.last ? seq_end : 32'($urandom);
            option_byte_q.push_back(it);
        end
        area_buf.delete();
    endfunction

    function automatic int queue_random_area();
        int          pick;
        int          nblk;
        int          mode;
        int          cut;
        int          n;
        logic [31:0] base;
        logic [31:0] seq;
        logic [31:0] lft [4];
        logic [31:0] rgt [4];
        logic [7:0]  kind;

        pick = $urandom_range(0, 99);
        seq = $urandom;
        if (pick < 75) begin
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 5))
                    0: area_buf.push_back(KindNop);
                    1: area_buf.push_back(KindEnd);
                    2: begin
                        area_buf.push_back(KindMss);
                        area_buf.push_back(8'd4);
                        repeat (2) area_buf.push_back(8'($urandom));
                    end
                    3: begin
                        area_buf.push_back(KindWscale);
                        area_buf.push_back(8'd3);
                        area_buf.push_back(8'($urandom));
                    end
                    4: begin
                        area_buf.push_back(KindSackPerm);
                        area_buf.push_back(8'd2);
                    end
                    default: begin
                        area_buf.push_back(KindTstamp);
                        area_buf.push_back(8'd10);
                        repeat (8) area_buf.push_back(8'($urandom));
                    end
                endcase
            end

            pick = $urandom_range(0, 9);
            nblk = (pick < 1) ? 0 : (pick < 2) ? 1 : (pick < 4) ? 2 : (pick < 6) ? 3 : 4;
            area_buf.push_back(KindSack);
            area_buf.push_back(8'(2 + 8 * nblk));

            base = $urandom;
            if ($urandom_range(0, 7) == 0)
                base = 32'hFFFF_F000;
            seq = base - $urandom_range(0, 64);
            for (int k = 0; k < 4; k++) begin
                lft[k] = base + $urandom_range(0, 1 << 20);
                rgt[k] = lft[k] + $urandom_range(0, 4096);
            end
            mode = $urandom_range(0, 3);
            if (mode == 1) begin
                // first block at or behind the local sequence
                lft[0] = seq - $urandom_range(0, 5000);
            end else if (mode == 2) begin
                // first block nested in the second
                lft[0] = lft[1] + $urandom_range(0, rgt[1] - lft[1]);
                rgt[0] = lft[0] + $urandom_range(0, rgt[1] - lft[0]);
            end else if (mode == 3) begin
                for (int k = 0; k < 4; k++) begin
                    lft[k] = $urandom;
                    rgt[k] = $urandom;
                end
                seq = $urandom;
            end
            for (int k = 0; k < nblk; k++) begin
                push_word(lft[k]);
                push_word(rgt[k]);
            end
            repeat ($urandom_range(0, 3)) area_buf.push_back(8'($urandom));

            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, area_buf.size());
                while (area_buf.size() > cut)
                    void'(area_buf.pop_back());
            end
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    do
                        kind = 8'($urandom_range(6, 255));
                    while (kind == KindTstamp);
                    area_buf.push_back(kind);
                    repeat ($urandom_range(0, 5)) area_buf.push_back(8'($urandom));
                end
                1: begin
                    area_buf.push_back(KindSack);
                    area_buf.push_back(8'($urandom));
                    repeat ($urandom_range(0, 10)) area_buf.push_back(8'($urandom));
                end
                2: begin
                    repeat ($urandom_range(1, 12)) area_buf.push_back(8'($urandom));
                end
                default: begin
                    area_buf.push_back(KindSack);
                    area_buf.push_back(8'(2 + 8 * $urandom_range(5, 31)));
                    repeat ($urandom_range(0, 6)) area_buf.push_back(8'($urandom));
                end
            endcase
        end
        n = area_buf.size();
        queue_area(seq);
        return n;
    endfunction

    task automatic wait_for_drain();
        @(posedge i_clk);
        while (option_byte_q.size() != 0 || s_valid || expected_sack_q.size() != 0)
            @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin : sender
        t_option_item nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_took) begin
            if (option_byte_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                nxt = option_byte_q.pop_front();
                s_data  <= {nxt.seq, nxt.opt};
                s_last  <= nxt.last;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (hold_req && !hold_done) begin
            // start the long hold-off, counted down here
            hold_done <= 1'b1;
            hold_left <= HoldOffCycles - 1;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_sack_list want;
        in_took <= i_rst_n && s_valid && s_ready;
        if (i_rst_n && s_valid && s_ready)
            advance_option_parser(s_data[7:0], s_last, s_data[39:8]);
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_sack_q.size() == 0) begin
                report_error($sformatf("unexpected result, count %0d", m_data[2:0]));
            end else begin
                want = expected_sack_q.pop_front();
                if (m_data[2:0] !== want.count)
                    report_error($sformatf("block_count %0d, expected %0d",
                                           m_data[2:0], want.count));
                for (int k = 0; k < NumBlocks; k++) begin
                    if (m_data[3+64*k +: 32] !== want.lft[k])
                        report_error($sformatf("left_edge_%0d %h, expected %h",
                                               k, m_data[3+64*k +: 32], want.lft[k]));
                    if (m_data[35+64*k +: 32] !== want.rgt[k])
                        report_error($sformatf("right_edge_%0d %h, expected %h",
                                               k, m_data[35+64*k +: 32], want.rgt[k]));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("tcp_sack_block_extractor test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int made;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone END, lone NOP
        area_buf.push_back(KindEnd);
        queue_area(32'h0000_0000);
        area_buf.push_back(KindNop);
        queue_area(32'hFFFF_FFFF);
        // unknown kind, trailing byte ignored
        area_buf.push_back(8'd6);
        area_buf.push_back(8'hFF);
        queue_area($urandom);
        // SACK with no room for blocks
        area_buf.push_back(KindSack);
        area_buf.push_back(8'd2);
        queue_area($urandom);
        // SACK length not a whole number of blocks
        area_buf.push_back(KindSack);
        area_buf.push_back(8'd3);
        queue_area($urandom);
        // SACK payload too long
        area_buf.push_back(KindSack);
        area_buf.push_back(8'd42);
        queue_area($urandom);
        // MSS cut short by the area end
        area_buf.push_back(KindMss);
        area_buf.push_back(8'd4);
        queue_area($urandom);
        // one block with extreme edges
        area_buf.push_back(KindSack);
        area_buf.push_back(8'd10);
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        queue_area(32'hFFFF_FFFF);

        made = 0;
        while (made < ItemsPerPhase)
            made += queue_random_area();

        // sender pauses until all results are back
        wait_for_drain();
        tx_idle_pct = 72;
        rx_idle_pct = 32;
        made = 0;
        while (made < ItemsPerPhase)
            made += queue_random_area();

        wait_for_drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long receiver stall while bytes keep coming
        hold_req = 1'b1;
        made = 0;
        while (made < ItemsPerPhase)
            made += queue_random_area();

        wait_for_drain();
        repeat (DrainCycles) @(posedge i_clk);
        while (expected_sack_q.size() != 0) begin
            void'(expected_sack_q.pop_front());
            report_error("expected result never arrived");
        end
        if (err_count == 0)
            $display("tcp_sack_block_extractor test passed");
        else
            $display("tcp_sack_block_extractor test failed");
        $finish;
    end

endmodule
